>>> rtl/cdpt_pkg.sv
package cdpt_pkg;

  // Default number of codebook slots built into the block
  localparam int MAX_CODEBOOKS_DEF = 16;

  // Fixed field widths
  localparam int CNT_W      = 5;
  localparam int LEN_W      = 13;
  localparam int TOK_W      = 12;
  localparam int OP_W       = 2;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int TDATA_W    = 16;

  // Operation codes carried on in_tuser
  localparam logic [OP_W-1:0] OP_STEP    = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_COUNT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FILL    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STOP    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN_GEN = 3'd5;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] RST_COUNT   = 5'd9;
  localparam logic [LEN_W-1:0] RST_LIMIT   = 13'd2580;
  localparam logic [TOK_W-1:0] RST_START   = 12'd1025;
  localparam logic [TOK_W-1:0] RST_FILL    = 12'd1024;
  localparam logic [TOK_W-1:0] RST_STOP    = 12'd1024;
  localparam logic [LEN_W-1:0] RST_MIN_GEN = 13'd0;

  // Settings the delay mask needs for one beat
  typedef struct packed {
    logic [LEN_W-1:0] length_limit;
    logic [LEN_W-1:0] seq_length;
    logic [TOK_W-1:0] start_token;
    logic [TOK_W-1:0] fill_token;
  } cdpt_mask_cfg_t;

endpackage

>>> rtl/cdpt_delay_mask.sv
module cdpt_delay_mask
  import cdpt_pkg::*;
#(
  parameter int MAX_CODEBOOKS = MAX_CODEBOOKS_DEF,
  localparam int NW = $clog2(MAX_CODEBOOKS + 1),
  localparam int IW = (MAX_CODEBOOKS > 1) ? $clog2(MAX_CODEBOOKS) : 1
) (
  input  cdpt_mask_cfg_t   mask_cfg,
  input  logic [NW-1:0]    n_books,
  input  logic [IW-1:0]    book,
  input  logic [TOK_W-1:0] stored_token,
  output logic [TOK_W-1:0] token_out
);

  logic [LEN_W-1:0] frame_pos;
  logic [14:0]      lim_w;
  logic [14:0]      n_w;
  logic [14:0]      k_w;
  logic [14:0]      j_w;
  logic             masked;
  logic             in_head;
  logic             in_tail;

  always_comb begin
    frame_pos = (mask_cfg.seq_length == '0) ? '0 : mask_cfg.seq_length - LEN_W'(1);
    lim_w     = 15'(mask_cfg.length_limit);
    n_w       = 15'(n_books);
    k_w       = 15'(book);
    j_w       = 15'(frame_pos);
    // mask applies only when limit >= 2n - 1
    masked    = (lim_w + 15'd1) >= (n_w << 1);
    in_head   = j_w <= k_w;
    in_tail   = (j_w + n_w) >= (lim_w + 15'd1 + k_w);
    if (masked && in_head) begin
      token_out = mask_cfg.start_token;
    end else if (masked && in_tail) begin
      token_out = mask_cfg.fill_token;
    end else begin
      token_out = stored_token;
    end
  end

endmodule

>>> rtl/codebook_delay_pattern_tracker_unit.sv
// An accepted beat's first result beat is registered and shows in the next cycle.
// Append: one result beat, one input beat accepted per cycle unless output stalls.
// Step: n result beats (n = codebooks in use), one per cycle from the result
// register while out_tready is high; the next input beat is taken once the final
// step beat is loaded. Restart and the unused opcode give no result.
// Reset: synchronous, active low; restores register defaults and a fresh sequence.
module codebook_delay_pattern_tracker_unit
  import cdpt_pkg::*;
#(
  parameter int MAX_CODEBOOKS = MAX_CODEBOOKS_DEF,
  localparam int NW = $clog2(MAX_CODEBOOKS + 1),
  localparam int IW = (MAX_CODEBOOKS > 1) ? $clog2(MAX_CODEBOOKS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // [11:0] token, [15:12] zero
  input  logic [OP_W-1:0]       in_tuser,   // [1:0] opcode
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // [11:0] token_out, [12] forbid_stop,
                                            // [13] done_all, [14] rejected, [15] zero
  output logic                  out_tlast
);

  // Configuration registers
  logic [CNT_W-1:0] count_r;
  logic [LEN_W-1:0] limit_r;
  logic [TOK_W-1:0] start_r;
  logic [TOK_W-1:0] fill_r;
  logic [TOK_W-1:0] stop_r;
  logic [LEN_W-1:0] min_gen_r;

  // Sequence state
  logic [TOK_W-1:0]         column_r [MAX_CODEBOOKS];
  logic [MAX_CODEBOOKS-1:0] flags_r;
  logic [IW-1:0]            tracked_r;
  logic [LEN_W-1:0]         seq_r;
  logic [IW-1:0]            app_idx_r;

  // Step emission state
  logic          busy_r;
  logic [IW-1:0] emit_idx_r;

  // Result register
  logic             out_tvalid_r;
  logic [TOK_W-1:0] out_tok_r;
  logic             out_forbid_r;
  logic             out_done_r;
  logic             out_last_r;
  logic             out_rej_r;

  logic [OP_W-1:0]  in_op;
  logic [TOK_W-1:0] in_tok;
  logic             slot_free;
  logic             in_accept;

  logic [NW-1:0]            n_books;
  logic [MAX_CODEBOOKS-1:0] in_use;
  logic                     done_now;

  // Append path
  logic [IW-1:0]            app_idx;
  logic                     app_fin;
  logic [TOK_W-1:0]         app_tok;
  logic                     app_set_fin;
  logic                     app_wrap;
  logic [IW-1:0]            app_idx_nxt;
  logic [LEN_W-1:0]         seq_app_nxt;
  logic [MAX_CODEBOOKS-1:0] flags_app_nxt;
  logic                     app_done;
  logic                     at_limit;

  // Step path
  logic [IW-1:0]    tracked_nxt;
  logic [IW-1:0]    beat_k;
  logic [TOK_W-1:0] beat_tok;
  logic             beat_forbid;
  logic             beat_last;
  logic             early;
  cdpt_mask_cfg_t   mask_cfg;

  assign in_op  = in_tuser;
  assign in_tok = in_tdata[TOK_W-1:0];

  // Hold input while a step is still emitting or the result slot is occupied
  assign slot_free = !out_tvalid_r || out_tready;
  assign in_tready = !busy_r && slot_free;
  assign in_accept = in_tvalid && in_tready;

  // Codebooks in use: zero counts as one, clamp to the built-in slots
  always_comb begin
    if (count_r == '0) begin
      n_books = NW'(1);
    end else if (int'(count_r) > MAX_CODEBOOKS) begin
      n_books = NW'(MAX_CODEBOOKS);
    end else begin
      n_books = NW'(count_r);
    end
    for (int i = 0; i < MAX_CODEBOOKS; i++) begin
      in_use[i] = (i < int'(n_books));
    end
  end

  assign at_limit = seq_r >= limit_r;
  assign done_now = at_limit || (&(flags_r | ~in_use));

  // Append: next codebook in order, PAD after EOS, EOS marks the book finished
  always_comb begin
    app_idx     = (NW'(app_idx_r) >= n_books) ? '0 : app_idx_r;
    app_fin     = flags_r[app_idx];
    app_tok     = app_fin ? fill_r : in_tok;
    app_set_fin = !app_fin && (in_tok == stop_r);
    app_wrap    = (NW'(app_idx) + NW'(1)) >= n_books;
    app_idx_nxt = app_wrap ? '0 : IW'(app_idx + IW'(1));
    seq_app_nxt = app_wrap ? seq_r + LEN_W'(1) : seq_r;
    for (int i = 0; i < MAX_CODEBOOKS; i++) begin
      flags_app_nxt[i] = flags_r[i] || (app_set_fin && (IW'(i) == app_idx));
    end
    app_done = (seq_app_nxt >= limit_r) || (&(flags_app_nxt | ~in_use));
  end

  // Step pointer: skip a book that saw EOS (any if start == stop), up to the last
  always_comb begin
    tracked_nxt = tracked_r;
    if ((NW'(tracked_r) < n_books) && (flags_r[tracked_r] || (start_r == stop_r)) &&
        ((NW'(tracked_r) + NW'(1)) < n_books)) begin
      tracked_nxt = IW'(tracked_r + IW'(1));
    end
  end

  // Beat zero leaves with the accepted step; the rest follow from emit_idx_r
  assign beat_k = busy_r ? emit_idx_r : '0;

  assign mask_cfg.length_limit = limit_r;
  assign mask_cfg.seq_length   = seq_r;
  assign mask_cfg.start_token  = start_r;
  assign mask_cfg.fill_token   = fill_r;

  cdpt_delay_mask #(
    .MAX_CODEBOOKS(MAX_CODEBOOKS)
  ) u_mask (
    .mask_cfg    (mask_cfg),
    .n_books     (n_books),
    .book        (beat_k),
    .stored_token(column_r[beat_k]),
    .token_out   (beat_tok)
  );

  assign early       = (min_gen_r != '0) && (seq_r != '0) &&
                       ((seq_r - LEN_W'(1)) < min_gen_r);
  // beat zero never exceeds the pointer, so the old pointer serves there too
  assign beat_forbid = early || (beat_k > tracked_r);
  assign beat_last   = (NW'(beat_k) + NW'(1)) == n_books;

  // Configuration and sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= RST_COUNT;
      limit_r   <= RST_LIMIT;
      start_r   <= RST_START;
      fill_r    <= RST_FILL;
      stop_r    <= RST_STOP;
      min_gen_r <= RST_MIN_GEN;
      flags_r   <= '0;
      tracked_r <= '0;
      seq_r     <= LEN_W'(1);
      app_idx_r <= '0;
      for (int i = 0; i < MAX_CODEBOOKS; i++) begin
        column_r[i] <= RST_START;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_COUNT:   count_r   <= cfg_wdata[CNT_W-1:0];
          REG_LIMIT:   limit_r   <= cfg_wdata[LEN_W-1:0];
          REG_START:   start_r   <= cfg_wdata[TOK_W-1:0];
          REG_FILL:    fill_r    <= cfg_wdata[TOK_W-1:0];
          REG_STOP:    stop_r    <= cfg_wdata[TOK_W-1:0];
          REG_MIN_GEN: min_gen_r <= cfg_wdata[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        case (in_op)
          OP_RESTART: begin
            flags_r   <= '0;
            tracked_r <= '0;
            seq_r     <= LEN_W'(1);
            app_idx_r <= '0;
            for (int i = 0; i < MAX_CODEBOOKS; i++) begin
              column_r[i] <= start_r;
            end
          end
          OP_APPEND: begin
            // drop the token once the length limit is reached
            if (!at_limit) begin
              column_r[app_idx] <= app_tok;
              flags_r           <= flags_app_nxt;
              seq_r             <= seq_app_nxt;
              app_idx_r         <= app_idx_nxt;
            end
          end
          OP_STEP: begin
            tracked_r <= tracked_nxt;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register and step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      busy_r       <= 1'b0;
      emit_idx_r   <= '0;
    end else if (slot_free) begin
      if (busy_r) begin
        out_tvalid_r <= 1'b1;
        if (beat_last) begin
          busy_r <= 1'b0;
        end else begin
          emit_idx_r <= IW'(emit_idx_r + IW'(1));
        end
      end else if (in_accept && (in_op == OP_STEP)) begin
        out_tvalid_r <= 1'b1;
        busy_r       <= !beat_last;
        emit_idx_r   <= IW'(1);
      end else if (in_accept && (in_op == OP_APPEND)) begin
        out_tvalid_r <= 1'b1;
      end else begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Result payload: no reset needed
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (busy_r || (in_accept && (in_op == OP_STEP))) begin
        out_tok_r    <= beat_tok;
        out_forbid_r <= beat_forbid;
        out_done_r   <= done_now;
        out_last_r   <= beat_last;
        out_rej_r    <= 1'b0;
      end else if (at_limit) begin
        out_tok_r    <= '0;
        out_forbid_r <= 1'b0;
        out_done_r   <= 1'b1;
        out_last_r   <= 1'b1;
        out_rej_r    <= 1'b1;
      end else begin
        out_tok_r    <= app_tok;
        out_forbid_r <= 1'b0;
        out_done_r   <= app_done;
        out_last_r   <= 1'b1;
        out_rej_r    <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_rej_r, out_done_r, out_forbid_r, out_tok_r};

`ifndef NO_ASSERTIONS
  // Sequence state must not move while a step is still being emitted
  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> ($stable(seq_r) && $stable(flags_r)))
    else $error("sequence state changed during step emission");

  // A rejected append always closes the item and reports done
  a_reject_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_rej_r) |-> (out_last_r && out_done_r))
    else $error("rejected beat without last or done");

  // Loading the final step beat releases the sequencer
  a_step_release: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && slot_free && beat_last) |=> !busy_r)
    else $error("sequencer stuck after final step beat");

  // An accepted step shows its first beat in the next cycle
  a_step_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_op == OP_STEP)) |=> out_tvalid_r)
    else $error("step accepted without a result beat");
`endif

endmodule
